FILE: sv/srfr_pkg.sv
// Shared types and constants for the servo reply frame receiver.
`default_nettype none
package srfr_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SIZE_ERR = 2'd1,
        ST_SUM_ERR  = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    localparam logic       REG_FRAME_LENGTH = 1'b0;
    localparam logic       REG_TIMEOUT_MS   = 1'b1;

    localparam logic [7:0]  HEADER_BYTE  = 8'hFF;
    localparam logic [7:0]  CHECK_MASK   = 8'hFE;
    localparam logic [5:0]  MIN_FRAME    = 6'd7;
    localparam logic [5:0]  FL_RESET     = 6'd9;
    localparam logic [15:0] TO_RESET     = 16'd100;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

    localparam logic [5:0]  IDX_HUNT     = 6'd0;
    localparam logic [5:0]  IDX_HDR2     = 6'd1;
    localparam logic [5:0]  IDX_SIZE     = 6'd2;
    localparam logic [5:0]  IDX_ID       = 6'd3;
    localparam logic [5:0]  IDX_CMD      = 6'd4;
    localparam logic [5:0]  IDX_CHK1     = 6'd5;
    localparam logic [5:0]  IDX_CHK2     = 6'd6;
    localparam logic [5:0]  IDX_DATA0    = 6'd7;
    localparam logic [5:0]  IDX_DATA3    = 6'd10;

    typedef struct packed {
        logic [5:0]  frame_len;   // clamped length
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        status_t         status;
        logic [3:0][7:0] data;
        logic [7:0]      command_code;
        logic [7:0]      servo_id;
    } res_t;

endpackage
`default_nettype wire

FILE: sv/srfr_cfg.sv
// APB register file for frame length and timeout, with length clamping.
`default_nettype none
module srfr_cfg
    import srfr_pkg::*;
#(
    parameter int MAX_FRAME = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output cfg_t             cfg
);

    localparam logic [5:0] MAX_LEN = (MAX_FRAME > 63) ? 6'd63 : 6'(MAX_FRAME);

    logic [5:0]  frame_length_reg;
    logic [15:0] timeout_ms_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= FL_RESET;
            timeout_ms_reg   <= TO_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[5:0];
                REG_TIMEOUT_MS:   timeout_ms_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_LENGTH: prdata = {26'd0, frame_length_reg};
            REG_TIMEOUT_MS:   prdata = {16'd0, timeout_ms_reg};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (frame_length_reg < MIN_FRAME) begin
            cfg.frame_len = MIN_FRAME;
        end else if (frame_length_reg > MAX_LEN) begin
            cfg.frame_len = MAX_LEN;
        end else begin
            cfg.frame_len = frame_length_reg;
        end
        cfg.timeout_ms = timeout_ms_reg;
    end

endmodule
`default_nettype wire

FILE: sv/srfr_deframer.sv
// Frame state, header hunt, byte capture, checksum and timeout decision.
`default_nettype none
module srfr_deframer
    import srfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output res_t            res
);

    logic            armed_reg,      armed_next;
    logic [5:0]      byte_index_reg, byte_index_next;
    logic [7:0]      xor_sum_reg,    xor_sum_next;
    logic [7:0]      size_byte_reg,  size_byte_next;
    logic [7:0]      check_one_reg,  check_one_next;
    logic [7:0]      check_two_reg,  check_two_next;
    logic [7:0]      id_byte_reg,    id_byte_next;
    logic [7:0]      cmd_byte_reg,   cmd_byte_next;
    logic [3:0][7:0] data_reg,       data_next;
    logic [15:0]     elapsed_reg,    elapsed_next;

    logic            timeout_hit;
    logic            frame_done;
    logic [7:0]      c1;
    logic [7:0]      c2;

    always_comb begin
        armed_next      = armed_reg;
        byte_index_next = byte_index_reg;
        xor_sum_next    = xor_sum_reg;
        size_byte_next  = size_byte_reg;
        check_one_next  = check_one_reg;
        check_two_next  = check_two_reg;
        id_byte_next    = id_byte_reg;
        cmd_byte_next   = cmd_byte_reg;
        data_next       = data_reg;
        elapsed_next    = elapsed_reg;
        timeout_hit     = 1'b0;
        frame_done      = 1'b0;

        unique case (mode)
            MODE_START: begin
                armed_next      = 1'b1;
                byte_index_next = '0;
                xor_sum_next    = '0;
                size_byte_next  = '0;
                check_one_next  = '0;
                check_two_next  = '0;
                id_byte_next    = '0;
                cmd_byte_next   = '0;
                data_next       = '0;
                elapsed_next    = '0;
            end
            MODE_TICK: begin
                if (armed_reg) begin
                    if (elapsed_reg != ELAPSED_MAX) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                    if (elapsed_next >= cfg.timeout_ms) begin
                        timeout_hit = 1'b1;
                    end
                end
            end
            MODE_BYTE: begin
                if (armed_reg) begin
                    if (elapsed_reg >= cfg.timeout_ms) begin
                        timeout_hit = 1'b1;
                    end else if (byte_index_reg == IDX_HUNT) begin
                        if (rx_byte == HEADER_BYTE) begin
                            byte_index_next = IDX_HDR2;
                        end
                    end else if (byte_index_reg == IDX_HDR2) begin
                        byte_index_next = (rx_byte == HEADER_BYTE) ? IDX_SIZE : IDX_HUNT;
                    end else begin
                        if (byte_index_reg == IDX_SIZE) size_byte_next = rx_byte;
                        if (byte_index_reg == IDX_ID)   id_byte_next   = rx_byte;
                        if (byte_index_reg == IDX_CMD)  cmd_byte_next  = rx_byte;
                        if (byte_index_reg == IDX_CHK1) check_one_next = rx_byte;
                        if (byte_index_reg == IDX_CHK2) check_two_next = rx_byte;
                        if (byte_index_reg >= IDX_DATA0 && byte_index_reg <= IDX_DATA3) begin
                            data_next[2'(byte_index_reg - IDX_DATA0)] = rx_byte;
                        end
                        // checksum skips the two checksum bytes themselves
                        if (byte_index_reg <= IDX_CMD || byte_index_reg >= IDX_DATA0) begin
                            xor_sum_next = xor_sum_reg ^ rx_byte;
                        end
                        byte_index_next = byte_index_reg + 6'd1;
                        if (byte_index_next >= cfg.frame_len) begin
                            frame_done = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (timeout_hit || frame_done) begin
            armed_next = 1'b0;
        end
    end

    assign c1 = xor_sum_next & CHECK_MASK;
    assign c2 = ~c1 & CHECK_MASK;

    always_comb begin
        res_valid = timeout_hit || frame_done;
        res       = '0;
        if (timeout_hit) begin
            res.status = ST_TIMEOUT;
        end else begin
            if (size_byte_next != {2'd0, cfg.frame_len}) begin
                res.status = ST_SIZE_ERR;
            end else if (check_one_next != c1 || check_two_next != c2) begin
                res.status = ST_SUM_ERR;
            end else begin
                res.status = ST_OK;
            end
            res.servo_id     = id_byte_next;
            res.command_code = cmd_byte_next;
            for (int k = 0; k < 4; k++) begin
                if (cfg.frame_len > IDX_DATA0 + 6'(k)) begin
                    res.data[k] = data_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            byte_index_reg <= '0;
            xor_sum_reg    <= '0;
            size_byte_reg  <= '0;
            check_one_reg  <= '0;
            check_two_reg  <= '0;
            id_byte_reg    <= '0;
            cmd_byte_reg   <= '0;
            data_reg       <= '0;
            elapsed_reg    <= '0;
        end else if (fire) begin
            armed_reg      <= armed_next;
            byte_index_reg <= byte_index_next;
            xor_sum_reg    <= xor_sum_next;
            size_byte_reg  <= size_byte_next;
            check_one_reg  <= check_one_next;
            check_two_reg  <= check_two_next;
            id_byte_reg    <= id_byte_next;
            cmd_byte_reg   <= cmd_byte_next;
            data_reg       <= data_next;
            elapsed_reg    <= elapsed_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/servo_reply_frame_receiver_top.sv
// Top level of the servo reply frame receiver: input stage, deframer, result register.
`default_nettype none
// Takes one item per clock: mode in s_tuser (0 start, 1 received byte, 2 one ms tick)
// and the byte in s_tdata. An item passes an input register, the deframer logic
// and a result register, which drives m_tvalid. While a result waits one more item is
// taken into the input register; the input stalls only when both registers are full
// and m_tready is low. Frame length is clamped to 7..MAX_FRAME, but never above 63.
module servo_reply_frame_receiver_top
    import srfr_pkg::*;
#(
    parameter int MAX_FRAME = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // servo_id, command_code, data_0..data_3
    output logic      [1:0]  m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       proc_fire;
    logic       res_valid;
    res_t       res;

    assign pready    = 1'b1;
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    srfr_cfg #(
        .MAX_FRAME (MAX_FRAME)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    srfr_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .mode      (in_mode_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.data[3], out_reg.data[2], out_reg.data[1], out_reg.data[0],
                       out_reg.command_code, out_reg.servo_id};

    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_TIMEOUT |-> m_tdata == '0)
        else $error("timeout result carries frame data");

    a_rise_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(proc_fire))
        else $error("result appeared without a processed item");

    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_mode_reg == MODE_START |=> !$rose(m_tvalid))
        else $error("start item produced a result");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while both stages are full");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the servo reply frame receiver: stream driver, monitor, APB setup, predictor.
module tb_top
    import srfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         FRAME_MAX     = 32;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         PHASES        = 8;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [2:0] ADDR_FRAME_LENGTH = {REG_FRAME_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_TIMEOUT_MS   = {REG_TIMEOUT_MS, 2'b00};

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] value;
    } rx_event_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [47:0] m_tdata;   // servo_id, command_code, data_0..data_3
    wire  [1:0]  m_tuser;   // [1:0] status
    wire  [31:0] prdata;
    wire         pready;

    servo_reply_frame_receiver_top #(.MAX_FRAME(FRAME_MAX)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    rx_event_t   events_to_send[$];
    res_t        replies_due[$];
    int          queued_count = 0;
    int          fail_count   = 0;
    bit          quiet_mode   = 1'b0;
    int          send_gap     = 0;
    int          ready_hold   = 0;
    int          stall_cycles = 0;

    // predictor state and register copies
    logic [5:0]  cur_frame_len = FL_RESET;
    logic [15:0] cur_timeout   = TO_RESET;
    bit          rx_armed      = 1'b0;
    logic [5:0]  rx_index      = '0;
    logic [7:0]  rx_xor        = '0;
    logic [7:0]  rx_size       = '0;
    logic [7:0]  rx_chk1       = '0;
    logic [7:0]  rx_chk2       = '0;
    logic [7:0]  rx_id         = '0;
    logic [7:0]  rx_cmd        = '0;
    logic [7:0]  rx_data [4]   = '{default: '0};
    logic [15:0] rx_elapsed    = '0;

    int          phase_len [PHASES] = '{7, 32, 0, 63, 12, 20, 7, 9};
    int          phase_to  [PHASES] = '{100, 65535, 40, 8, 0, 300, 50, 100};
    int          phase_cnt [PHASES] = '{150, 150, 150, 150, 100, 150, 150, 200};

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
            $display("%0t ERROR %s", $time, msg);
        fail_count++;
    endtask

    function automatic int clamped_len();
        if (cur_frame_len < MIN_FRAME)
            return MIN_FRAME;
        if (cur_frame_len > FRAME_MAX)
            return FRAME_MAX;
        return cur_frame_len;
    endfunction

    function automatic void give_timeout();
        res_t r;
        r = '0;
        r.status = ST_TIMEOUT;
        rx_armed = 1'b0;
        replies_due.push_back(r);
    endfunction

    task automatic deframe_item(input rx_event_t ev);
        res_t       r;
        int         len;
        logic [7:0] c1;
        logic [7:0] c2;
        r = '0;
        len = clamped_len();
        if (ev.mode == MODE_START) begin
            rx_armed = 1'b1;
            rx_index = IDX_HUNT;
            rx_xor = '0;
            rx_size = '0;
            rx_chk1 = '0;
            rx_chk2 = '0;
            rx_id = '0;
            rx_cmd = '0;
            foreach (rx_data[k])
                rx_data[k] = '0;
            rx_elapsed = '0;
        end else if (ev.mode == MODE_UNUSED || !rx_armed) begin
        end else if (ev.mode == MODE_TICK) begin
            if (rx_elapsed != ELAPSED_MAX)
                rx_elapsed++;
            if (rx_elapsed >= cur_timeout)
                give_timeout();
        end else if (rx_elapsed >= cur_timeout) begin
            give_timeout();
        end else if (rx_index == IDX_HUNT) begin
            if (ev.value == HEADER_BYTE)
                rx_index = IDX_HDR2;
        end else if (rx_index == IDX_HDR2) begin
            rx_index = (ev.value == HEADER_BYTE) ? IDX_SIZE : IDX_HUNT;
        end else begin
            case (rx_index)
                IDX_SIZE: rx_size = ev.value;
                IDX_ID:   rx_id = ev.value;
                IDX_CMD:  rx_cmd = ev.value;
                IDX_CHK1: rx_chk1 = ev.value;
                IDX_CHK2: rx_chk2 = ev.value;
                default: begin
                    if (rx_index >= IDX_DATA0 && rx_index <= IDX_DATA3)
                        rx_data[rx_index - IDX_DATA0] = ev.value;
                end
            endcase
            if (rx_index <= IDX_CMD || rx_index >= IDX_DATA0)
                rx_xor ^= ev.value;
            rx_index = rx_index + 6'd1;
            if (rx_index >= len) begin
                c1 = rx_xor & CHECK_MASK;
                c2 = ~c1 & CHECK_MASK;
                if (rx_size != len)
                    r.status = ST_SIZE_ERR;
                else if (rx_chk1 != c1 || rx_chk2 != c2)
                    r.status = ST_SUM_ERR;
                else
                    r.status = ST_OK;
                r.servo_id = rx_id;
                r.command_code = rx_cmd;
                for (int k = 0; k < 4; k++)
                    r.data[k] = (IDX_DATA0 + k < len) ? rx_data[k] : 8'h00;
                rx_armed = 1'b0;
                replies_due.push_back(r);
            end
        end
    endtask

    // stream driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(0, 18);
                s_tvalid <= 1'b0;
            end else if (events_to_send.size() != 0) begin
                rx_event_t ev;
                ev = events_to_send.pop_front();
                s_tdata <= ev.value;
                s_tuser <= ev.mode;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 11) == 0) begin
            ready_hold = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check results, then predict from accepted items
    always @(posedge aclk) begin : monitor
        res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d data %h",
                                              m_tuser, m_tdata));
                end else begin
                    want = replies_due.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_tuser, want.status));
                    if (m_tdata[7:0] !== want.servo_id)
                        report_mismatch($sformatf("servo_id got %h want %h",
                                                  m_tdata[7:0], want.servo_id));
                    if (m_tdata[15:8] !== want.command_code)
                        report_mismatch($sformatf("command_code got %h want %h",
                                                  m_tdata[15:8], want.command_code));
                    for (int k = 0; k < 4; k++)
                        if (m_tdata[16 + 8*k +: 8] !== want.data[k])
                            report_mismatch($sformatf("data_%0d got %h want %h", k,
                                                      m_tdata[16 + 8*k +: 8], want.data[k]));
                end
            end
            if (s_tvalid && s_tready)
                deframe_item('{mode: s_tuser, value: s_tdata});
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d items queued, %0d results outstanding",
                         events_to_send.size(), replies_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic void push_event(input logic [1:0] mode, input logic [7:0] value);
        events_to_send.push_back('{mode: mode, value: value});
        queued_count++;
    endfunction

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (events_to_send.size() != 0 || s_tvalid || replies_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_FRAME_LENGTH)
            cur_frame_len = val[5:0];
        else
            cur_timeout = val[15:0];
    endtask

    task automatic send_random_events(input int count);
        int         target;
        int         kind;
        int         len;
        int         stop;
        int         n;
        logic [7:0] body [FRAME_MAX];
        logic [7:0] sum;
        target = queued_count + count;
        while (queued_count < target) begin
            len = clamped_len();
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                push_event(MODE_START, 8'($urandom));
                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        push_event(MODE_BYTE, 8'($urandom_range(0, 254)));
                    end else begin
                        push_event(MODE_BYTE, HEADER_BYTE);
                        push_event(MODE_BYTE, 8'($urandom_range(0, 254)));
                    end
                end
                push_event(MODE_BYTE, HEADER_BYTE);
                push_event(MODE_BYTE, HEADER_BYTE);
                body[IDX_SIZE] = ($urandom_range(0, 9) == 0) ?
                                 8'(len ^ $urandom_range(1, 255)) : 8'(len);
                body[IDX_ID] = 8'($urandom);
                body[IDX_CMD] = 8'($urandom);
                sum = body[IDX_SIZE] ^ body[IDX_ID] ^ body[IDX_CMD];
                for (int i = IDX_DATA0; i < len; i++) begin
                    body[i] = 8'($urandom);
                    sum ^= body[i];
                end
                body[IDX_CHK1] = sum & CHECK_MASK;
                body[IDX_CHK2] = ~body[IDX_CHK1] & CHECK_MASK;
                if ($urandom_range(0, 9) == 0)
                    body[$urandom_range(IDX_CHK1, IDX_CHK2)] ^= 8'(1 << $urandom_range(0, 7));
                stop = ($urandom_range(0, 9) == 0) ? $urandom_range(IDX_SIZE, len - 1) : len;
                for (int i = IDX_SIZE; i < stop; i++) begin
                    push_event(MODE_BYTE, body[i]);
                    if ($urandom_range(0, 19) == 0)
                        push_event(MODE_TICK, 8'($urandom));
                end
            end else if (kind < 78) begin
                push_event(MODE_START, 8'($urandom));
                n = $urandom_range(0, (cur_timeout < 58) ? cur_timeout + 2 : 60);
                repeat (n)
                    push_event(($urandom_range(0, 5) == 0) ? MODE_BYTE : MODE_TICK,
                               8'($urandom));
            end else begin
                n = $urandom_range(1, 8);
                repeat (n)
                    push_event(2'($urandom_range(0, 3)),
                               ($urandom_range(0, 2) == 0) ? HEADER_BYTE : 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // idle receiver, header hunt with a skipped byte and a restart, good frame
        push_event(MODE_UNUSED, 8'hFF);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_TICK, 8'h00);
        push_event(MODE_START, 8'h00);
        push_event(MODE_BYTE, 8'h00);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_BYTE, 8'h7E);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_BYTE, 8'h09);
        push_event(MODE_BYTE, 8'h00);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_BYTE, 8'h08);
        push_event(MODE_BYTE, 8'hF6);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_BYTE, 8'h00);
        wait_idle();

        // zero timeout: first byte after start times out
        reg_write(ADDR_TIMEOUT_MS, 32'd0);
        push_event(MODE_START, 8'h00);
        push_event(MODE_BYTE, 8'h55);
        push_event(MODE_TICK, 8'h00);
        wait_idle();

        reg_write(ADDR_TIMEOUT_MS, 32'd2);
        push_event(MODE_START, 8'h00);
        push_event(MODE_TICK, 8'h00);
        push_event(MODE_BYTE, 8'hFF);
        push_event(MODE_TICK, 8'h00);
        wait_idle();

        // timeout lowered under a running reception
        reg_write(ADDR_TIMEOUT_MS, 32'd60);
        push_event(MODE_START, 8'h00);
        push_event(MODE_TICK, 8'h00);
        wait_idle();
        reg_write(ADDR_TIMEOUT_MS, 32'd1);
        push_event(MODE_BYTE, 8'h00);
        wait_idle();

        phase_len[6] = $urandom_range(MIN_FRAME, FRAME_MAX);
        phase_to[6] = $urandom_range(10, 200);
        for (int p = 0; p < PHASES; p++) begin
            quiet_mode = (p == PHASES - 1);
            reg_write(ADDR_FRAME_LENGTH, 32'(phase_len[p]));
            reg_write(ADDR_TIMEOUT_MS, 32'(phase_to[p]));
            send_random_events(phase_cnt[p] / 2);
            wait_idle();
            send_random_events(phase_cnt[p] - phase_cnt[p] / 2);
            wait_idle();
        end

        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: servo_reply_frame_receiver_top.f
sv/srfr_pkg.sv
sv/srfr_cfg.sv
sv/srfr_deframer.sv
sv/servo_reply_frame_receiver_top.sv
verif/tb_top.sv
